FILE: hdl/tcc_pkg.sv
// shared types, opcode, mode and bus source codes for the ttl cpu cycle core
// no dependencies
`timescale 1ns / 1ps

package tcc_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;

    // operation field, instruction bits 7..5
    localparam logic [2:0] OP_LD  = 3'd0;
    localparam logic [2:0] OP_AND = 3'd1;
    localparam logic [2:0] OP_OR  = 3'd2;
    localparam logic [2:0] OP_XOR = 3'd3;
    localparam logic [2:0] OP_ADD = 3'd4;
    localparam logic [2:0] OP_SUB = 3'd5;
    localparam logic [2:0] OP_ST  = 3'd6;
    localparam logic [2:0] OP_JMP = 3'd7;

    // addressing mode / destination field, instruction bits 4..2
    localparam logic [2:0] MODE_D_AC    = 3'd0;
    localparam logic [2:0] MODE_X_AC    = 3'd1;
    localparam logic [2:0] MODE_YD_AC   = 3'd2;
    localparam logic [2:0] MODE_YX_AC   = 3'd3;
    localparam logic [2:0] MODE_D_X     = 3'd4;
    localparam logic [2:0] MODE_D_Y     = 3'd5;
    localparam logic [2:0] MODE_D_OUT   = 3'd6;
    localparam logic [2:0] MODE_YXI_OUT = 3'd7;

    // bus source field, instruction bits 1..0
    localparam logic [1:0] BUS_D   = 2'd0;
    localparam logic [1:0] BUS_RAM = 2'd1;
    localparam logic [1:0] BUS_AC  = 2'd2;
    localparam logic [1:0] BUS_IN  = 2'd3;

    localparam word_t PAGE_MASK = 16'hff00;

    // full 16-bit data address an instruction uses, before ram width reduction
    function automatic word_t mem_addr(input byte_t ir, input byte_t d,
                                       input byte_t x, input byte_t y);
        word_t a;
        a = {8'h00, d};
        if (ir[7:5] != OP_JMP)
        begin
            case (ir[4:2])
                MODE_X_AC:    a = {8'h00, x};
                MODE_YD_AC:   a = {y, d};
                MODE_YX_AC:   a = {y, x};
                MODE_YXI_OUT: a = {y, x};
                default:      a = {8'h00, d};
            endcase
        end
        return a;
    endfunction

endpackage

FILE: hdl/tcc_ram.sv
// generic single-port-write, one-read ram with registered read data
// no dependencies; read-first when read and write hit the same address
`timescale 1ns / 1ps

module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/ttl_cpu_cycle_core.sv
// top level: one clock cycle of the 8-bit ttl cpu per word, with its data ram
// depends on tcc_pkg and tcc_ram
// result: a result word is registered and valid in the cycle after an input word is accepted
// throughput: one word per cycle while out_ready is high; the ram read for the next
// instruction is launched at the edge that latches it, so the ram port sets the rate
// reset: rst_n clears pc, latched instruction, AC, X, Y, OUT and the config
// register at once; ram contents stay undefined and no clearing pass is run
`timescale 1ns / 1ps

module ttl_cpu_cycle_core #(
    parameter int RAM_ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // config: bus value for a store that names ram as its source
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,

    // fetched word
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  fetched_instruction,
    input  logic [7:0]  fetched_data,
    input  logic [7:0]  input_port,

    // result word
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] next_pc,
    output logic [7:0]  accumulator,
    output logic [7:0]  index_x,
    output logic [7:0]  index_y,
    output logic [7:0]  output_port,
    output logic        ram_written,
    output logic [15:0] ram_write_address,
    output logic [7:0]  ram_write_value
);

    localparam int          RAM_DEPTH = 1 << RAM_ADDR_BITS;
    localparam logic [15:0] RAM_MASK  = 16'((32'd1 << RAM_ADDR_BITS) - 32'd1);

    // architectural state; the result fields for AC, X, Y, OUT and pc are
    // read straight from these, since they only move when the result is taken
    tcc_pkg::word_t pc_reg,  pc_next;
    tcc_pkg::byte_t ir_reg;
    tcc_pkg::byte_t d_reg;
    tcc_pkg::byte_t ac_reg,  ac_next;
    tcc_pkg::byte_t x_reg,   x_next;
    tcc_pkg::byte_t y_reg,   y_next;
    tcc_pkg::byte_t out_port_reg, out_port_next;
    tcc_pkg::byte_t cfg_bus_reg;

    // result side
    logic           out_valid_reg;
    logic           wrote_reg;
    tcc_pkg::word_t wr_addr_out_reg;
    tcc_pkg::byte_t wr_val_out_reg;

    // store-to-load bypass around the read-first ram
    logic           fwd_hit_reg;
    tcc_pkg::byte_t fwd_val_reg;

    logic           accept;

    // decode of the latched instruction
    logic [2:0]     op;
    logic [2:0]     mode;
    logic [1:0]     src;
    logic           is_store;
    logic           is_jump;

    tcc_pkg::word_t exec_addr;
    logic [RAM_ADDR_BITS-1:0] exec_ram_addr;
    logic [RAM_ADDR_BITS-1:0] rd_addr;
    tcc_pkg::byte_t ram_rd_data;
    tcc_pkg::byte_t ram_byte;
    tcc_pkg::byte_t bus;
    tcc_pkg::byte_t alu;
    logic [1:0]     cond_bit;
    logic           fwd_hit_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign op       = ir_reg[7:5];
    assign mode     = ir_reg[4:2];
    assign src      = ir_reg[1:0];
    assign is_store = (op == tcc_pkg::OP_ST);
    assign is_jump  = (op == tcc_pkg::OP_JMP);

    // address of the instruction now executing, reduced to the ram width
    assign exec_addr     = tcc_pkg::mem_addr(ir_reg, d_reg, x_reg, y_reg);
    assign exec_ram_addr = exec_addr[RAM_ADDR_BITS-1:0];

    // ram byte: the read was launched when this instruction was latched;
    // a store at that same edge to the same address is taken from the bypass
    assign ram_byte = fwd_hit_reg ? fwd_val_reg : ram_rd_data;

    always_comb
    begin
        case (src)
            tcc_pkg::BUS_D:   bus = d_reg;
            tcc_pkg::BUS_RAM: bus = is_store ? cfg_bus_reg : ram_byte;
            tcc_pkg::BUS_AC:  bus = ac_reg;
            tcc_pkg::BUS_IN:  bus = input_port;
            default:          bus = d_reg;
        endcase
    end

    always_comb
    begin
        case (op)
            tcc_pkg::OP_LD:  alu = bus;
            tcc_pkg::OP_AND: alu = ac_reg & bus;
            tcc_pkg::OP_OR:  alu = ac_reg | bus;
            tcc_pkg::OP_XOR: alu = ac_reg ^ bus;
            tcc_pkg::OP_ADD: alu = ac_reg + bus;
            tcc_pkg::OP_SUB: alu = ac_reg - bus;
            tcc_pkg::OP_ST:  alu = ac_reg;
            default:         alu = 8'h00 - ac_reg;
        endcase
    end

    // jump condition: bit 0 for AC positive, bit 1 for negative, bit 2 for zero
    always_comb
    begin
        if (ac_reg == 8'h00)
        begin
            cond_bit = 2'd2;
        end
        else if (ac_reg[7])
        begin
            cond_bit = 2'd1;
        end
        else
        begin
            cond_bit = 2'd0;
        end
    end

    // register writeback and next pc
    always_comb
    begin
        ac_next       = ac_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        out_port_next = out_port_reg;
        pc_next       = pc_reg + 16'd1;
        if (is_jump)
        begin
            if (mode == tcc_pkg::MODE_D_AC)
            begin
                // far jump
                pc_next = {y_reg, bus};
            end
            else if (mode[cond_bit])
            begin
                // in-page branch
                pc_next = (pc_reg & tcc_pkg::PAGE_MASK) | {8'h00, bus};
            end
        end
        else
        begin
            case (mode)
                tcc_pkg::MODE_D_X:   x_next = alu;
                tcc_pkg::MODE_D_Y:   y_next = alu;
                tcc_pkg::MODE_D_OUT:
                begin
                    if (!is_store)
                    begin
                        out_port_next = alu;
                    end
                end
                tcc_pkg::MODE_YXI_OUT:
                begin
                    if (!is_store)
                    begin
                        out_port_next = alu;
                    end
                    // post-increment happens for stores too
                    x_next = x_reg + 8'd1;
                end
                default:
                begin
                    if (!is_store)
                    begin
                        ac_next = alu;
                    end
                end
            endcase
        end
    end

    // ram read for the instruction being latched, using the post-update X and Y
    assign rd_addr = RAM_ADDR_BITS'(tcc_pkg::mem_addr(fetched_instruction, fetched_data,
                                                      x_next, y_next));
    assign fwd_hit_next = is_store && (exec_ram_addr == rd_addr);

    tcc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (accept && is_store),
        .wr_addr (exec_ram_addr),
        .wr_data (bus),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // config register; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bus_reg <= 8'h00;
        end
        else if (cfg_write_en)
        begin
            cfg_bus_reg <= cfg_write_data;
        end
    end

    // architectural state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 16'h0000;
            ir_reg        <= 8'h00;
            d_reg         <= 8'h00;
            ac_reg        <= 8'h00;
            x_reg         <= 8'h00;
            y_reg         <= 8'h00;
            out_port_reg  <= 8'h00;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pc_reg        <= pc_next;
                ir_reg        <= fetched_instruction;
                d_reg         <= fetched_data;
                ac_reg        <= ac_next;
                x_reg         <= x_next;
                y_reg         <= y_next;
                out_port_reg  <= out_port_next;
                out_valid_reg <= 1'b1;
                fwd_hit_reg   <= fwd_hit_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // store report and bypass data (payload, no reset needed beyond the flag)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrote_reg <= 1'b0;
        end
        else if (accept)
        begin
            wrote_reg <= is_store;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_val_reg     <= bus;
            wr_addr_out_reg <= is_store ? (exec_addr & RAM_MASK) : 16'h0000;
            wr_val_out_reg  <= is_store ? bus : 8'h00;
        end
    end

    assign out_valid         = out_valid_reg;
    assign next_pc           = pc_reg;
    assign accumulator       = ac_reg;
    assign index_x           = x_reg;
    assign index_y           = y_reg;
    assign output_port       = out_port_reg;
    assign ram_written       = wrote_reg;
    assign ram_write_address = wr_addr_out_reg;
    assign ram_write_value   = wr_val_out_reg;

    // a word that does not store reports a zero address and value
    a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ram_written |-> ram_write_address == 16'h0000 &&
                                      ram_write_value == 8'h00)
        else $error("store fields nonzero without a store");

    // only a store instruction may report a ram write
    a_store_only: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_store |=> !ram_written)
        else $error("ram write reported for a non-store");

    // a non-jump instruction always steps the pc by one
    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_jump |=> pc_reg == $past(pc_reg) + 16'd1)
        else $error("pc did not step on a non-jump");

    // a store never changes AC
    a_store_keeps_ac: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_store |=> $stable(ac_reg))
        else $error("store changed AC");

endmodule
